### hw/rtl/sha256_message_padder_top_assert.svh
// Assertion macros shared by the padder modules.
// Each expects clk and rst_n to be in scope at the point of use.
`ifndef SHA256_MESSAGE_PADDER_TOP_ASSERT_SVH
`define SHA256_MESSAGE_PADDER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SMP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/smp_pkg.sv
package smp_pkg;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    // Word 14 of a block holds the high half of the length.
    localparam logic [3:0] LEN_WORD_IDX  = 4'd14;
    localparam logic [3:0] LAST_WORD_IDX = 4'd15;

    typedef struct packed {
        logic load_byte;
        logic emit_mark;
        logic emit_zero;
        logic emit_len_hi;
        logic emit_len_lo;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic at_len_pos;
    } status_t;

endpackage

### hw/rtl/smp_byte_if.sv
interface smp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

### hw/rtl/smp_word_if.sv
interface smp_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] padded_word;
    logic        block_done;
    logic        message_done;

    modport source (output valid, output padded_word, output block_done,
                    output message_done, input ready);
    modport sink   (input valid, input padded_word, input block_done,
                    input message_done, output ready);
endinterface

### hw/rtl/smp_ctrl.sv
`include "sha256_message_padder_top_assert.svh"

module smp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    input  logic            byte_present,
    input  logic            end_of_message,
    output logic            ready,
    input  smp_pkg::status_t status,
    output smp_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MARK   = 2'd1;
    localparam logic [1:0] ST_FILL   = 2'd2;
    localparam logic [1:0] ST_LEN_LO = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign ready  = (state_reg == ST_IDLE) && status.slot_free;
    assign accept = valid && ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_byte = accept && byte_present;
                if (accept && end_of_message)
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_mark = 1'b1;
                    state_next    = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (status.slot_free)
                begin
                    if (status.at_len_pos)
                    begin
                        cmd.emit_len_hi = 1'b1;
                        state_next      = ST_LEN_LO;
                    end
                    else
                    begin
                        cmd.emit_zero = 1'b1;
                    end
                end
            end
            ST_LEN_LO:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_len_lo = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SMP_ASSERT_SAME(a_busy_blocks_input, state_reg != ST_IDLE, !ready, "input taken while padding")
    `SMP_ASSERT_NEXT(a_end_starts_pad, accept && end_of_message, state_reg == ST_MARK, "end beat did not start padding")
    `SMP_ASSERT_NEXT(a_len_lo_returns, (state_reg == ST_LEN_LO) && status.slot_free, state_reg == ST_IDLE, "no return to idle after length")

endmodule

### hw/rtl/smp_datapath.sv
`include "sha256_message_padder_top_assert.svh"

module smp_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  smp_pkg::cmd_t    cmd,
    output smp_pkg::status_t status,
    smp_word_if.source       padded
);

    // Byte count; the bit length is this value times eight.
    logic [60:0] cnt_reg;
    logic [60:0] cnt_next;
    logic [23:0] partial_reg;
    logic [23:0] partial_next;
    logic [5:0]  off_reg;
    logic [5:0]  off_next;
    logic        valid_reg;
    logic        valid_next;
    logic [31:0] word_reg;
    logic        bd_reg;
    logic        md_reg;

    logic        emit;
    logic [31:0] word_d;
    logic        bd_d;
    logic        md_d;
    logic [3:0]  idx;
    logic [1:0]  filled;
    logic [63:0] bit_len;

    assign idx     = off_reg[5:2];
    assign filled  = off_reg[1:0];
    assign bit_len = {cnt_reg, 3'b000};

    assign status.slot_free  = !valid_reg || padded.ready;
    assign status.at_len_pos = (idx == smp_pkg::LEN_WORD_IDX);

    always_comb
    begin
        cnt_next     = cnt_reg;
        partial_next = partial_reg;
        off_next     = off_reg;
        emit         = 1'b0;
        word_d       = '0;
        bd_d         = (idx == smp_pkg::LAST_WORD_IDX);
        md_d         = 1'b0;
        if (cmd.load_byte)
        begin
            cnt_next = cnt_reg + 61'd1;
            off_next = off_reg + 6'd1;
            if (filled == 2'd3)
            begin
                emit         = 1'b1;
                word_d       = {partial_reg, data_byte};
                partial_next = '0;
            end
            else
            begin
                partial_next = {partial_reg[15:0], data_byte};
            end
        end
        else if (cmd.emit_mark)
        begin
            emit = 1'b1;
            case (filled)
                2'd0:    word_d = {smp_pkg::PAD_MARK, 24'h000000};
                2'd1:    word_d = {partial_reg[7:0], smp_pkg::PAD_MARK, 16'h0000};
                2'd2:    word_d = {partial_reg[15:0], smp_pkg::PAD_MARK, 8'h00};
                default: word_d = {partial_reg, smp_pkg::PAD_MARK};
            endcase
            off_next     = {idx + 4'd1, 2'b00};
            partial_next = '0;
        end
        else if (cmd.emit_zero)
        begin
            emit     = 1'b1;
            off_next = off_reg + 6'd4;
        end
        else if (cmd.emit_len_hi)
        begin
            emit     = 1'b1;
            word_d   = bit_len[63:32];
            off_next = off_reg + 6'd4;
        end
        else if (cmd.emit_len_lo)
        begin
            emit         = 1'b1;
            word_d       = bit_len[31:0];
            bd_d         = 1'b1;
            md_d         = 1'b1;
            off_next     = '0;
            partial_next = '0;
            cnt_next     = '0;
        end
        valid_next = emit || (valid_reg && !padded.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            partial_reg <= '0;
            off_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            partial_reg <= partial_next;
            off_reg     <= off_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            word_reg <= word_d;
            bd_reg   <= bd_d;
            md_reg   <= md_d;
        end
    end

    assign padded.valid        = valid_reg;
    assign padded.padded_word  = word_reg;
    assign padded.block_done   = bd_reg;
    assign padded.message_done = md_reg;

    `SMP_ASSERT_SAME(a_one_op, 1'b1, $onehot0(cmd), "more than one datapath operation")
    `SMP_ASSERT_SAME(a_fill_aligned, cmd.emit_zero || cmd.emit_len_hi, off_reg[1:0] == 2'b00, "fill word not word aligned")
    `SMP_ASSERT_NEXT(a_clear_after_len, cmd.emit_len_lo, (off_reg == 6'd0) && (cnt_reg == 61'd0), "state not cleared after length")

endmodule

### hw/rtl/sha256_message_padder_top.sv
// SHA-256 message padder.
// msg (sink): one beat per message byte. byte_present marks a real byte;
//   end_of_message closes the message (a byte on the same beat goes first).
//   A beat with neither flag set is dropped.
// padded (source): one beat per 32-bit big-endian word of the padded
//   message. block_done flags the sixteenth word of each 512-bit block,
//   message_done the last word (low half of the bit length).
// A byte that completes a word shows its word on padded in the cycle
//   after the beat. Byte beats are taken one per cycle while the
//   receiver keeps up.
// After an end beat the sequencer in smp_ctrl runs a padding burst of 3
//   to 18 words, one word per cycle unless padded stalls; msg.ready stays
//   low until the length word has been loaded into the output register.
// A single output register parts the two sides: a stall on padded holds
//   the word and stops new words only when that register is still full.
// Reset (rst_n, async, active low) clears the length count, the byte
//   offset and the output valid; the next byte starts a new message.
module sha256_message_padder_top (
    input  logic      clk,
    input  logic      rst_n,
    smp_byte_if.sink  msg,
    smp_word_if.source padded
);

    smp_pkg::cmd_t    cmd;
    smp_pkg::status_t status;

    smp_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .valid          (msg.valid),
        .byte_present   (msg.byte_present),
        .end_of_message (msg.end_of_message),
        .ready          (msg.ready),
        .status         (status),
        .cmd            (cmd)
    );

    smp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (msg.data_byte),
        .cmd       (cmd),
        .status    (status),
        .padded    (padded)
    );

endmodule
